// File: sv/barcode_damerau_levenshtein_macros.svh
// Assertion macros for the barcode Damerau-Levenshtein block.
// Included by the top level only; depends on nothing else.
`ifndef BARCODE_DAMERAU_LEVENSHTEIN_MACROS_SVH
`define BARCODE_DAMERAU_LEVENSHTEIN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDL_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bdl_pkg.sv
// Shared constants for the barcode Damerau-Levenshtein block.
// Used by the top level; depends on nothing.
package bdl_pkg;

    localparam int SEQ_LEN_DEF     = 16;
    localparam int SYMBOL_BITS_DEF = 2;

    localparam int IN_FIELD_W = 32;   // width of each packed barcode
    localparam int DIST_W     = 5;    // width of the distance field
    localparam int MAXD_W     = 6;    // width of the limit register
    localparam int OUT_W      = 8;    // result tdata, padded to a byte
    localparam int OVER_BIT   = DIST_W;
    localparam int DIST_MAX   = (1 << DIST_W) - 1;

endpackage

// File: sv/bdl_score_mem.sv
// Score matrix storage: one write port and two registered read ports.
// Holds the interior cells of the matrix; no package dependency.
module bdl_score_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 6
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [DATA_W-1:0]        rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [DATA_W-1:0]        rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: sv/bdl_cell_unit.sv
// Shared min/add unit that scores one matrix cell per cycle.
// Combinational; used by the top level sequencer, no package dependency.
module bdl_cell_unit #(
    parameter int VAL_W = 6,
    parameter int IDX_W = 5,
    parameter int CNT_W = 4,
    parameter int TW    = 7
) (
    input  logic [VAL_W-1:0] diag,
    input  logic [VAL_W-1:0] left,
    input  logic [VAL_W-1:0] up,
    input  logic [VAL_W-1:0] trans_base,
    input  logic [CNT_W-1:0] ic,          // source row, counted from zero
    input  logic [CNT_W-1:0] jc,          // target column, counted from zero
    input  logic [IDX_W-1:0] row_match,
    input  logic [IDX_W-1:0] col_match,
    input  logic             match,
    output logic [VAL_W-1:0] score
);

    logic [VAL_W-1:0] m_du;
    logic [VAL_W-1:0] m_all;
    logic [TW-1:0]    trans;
    logic [TW-1:0]    subst;
    logic [TW-1:0]    res;

    always_comb
    begin
        m_du  = (diag < up) ? diag : up;
        m_all = (m_du < left) ? m_du : left;
        // Gap cost: (i - row_match - 1) + (j - col_match), both never negative.
        trans = TW'(trans_base) + TW'(ic) - TW'(row_match)
              + TW'(jc) + TW'(1) - TW'(col_match);
        subst = TW'(m_all) + TW'(1);
        if (match)
        begin
            res = (TW'(diag) < trans) ? TW'(diag) : trans;
        end
        else
        begin
            res = (trans < subst) ? trans : subst;
        end
        score = VAL_W'(res);
    end

endmodule

// File: sv/barcode_damerau_levenshtein.sv
// Barcode Damerau-Levenshtein distance, top level: handshake, sequencer,
// limit register. Uses bdl_pkg, bdl_score_mem, bdl_cell_unit and the macros.
//
// Usage:
//   The s_* channel takes one item: the source barcode in s_tdata[31:0] and
//   the target barcode in s_tdata[63:32], symbol k in bits of k times the
//   symbol width. The m_* channel returns one item per input item: the
//   distance in m_tdata[4:0] (saturated at 31) and the over-limit flag in
//   m_tdata[5]. cfg_wr_en with cfg_wr_data writes the distance limit; zero
//   turns the limit check off. Write it only while the block is idle.
//   The matrix is scored one cell per cycle by a single min/add unit behind a
//   registered memory read; the final cell score is registered and then loaded
//   into the output register.
//   s_tready is high only while no item is being scored; one item is taken
//   at a time, and a new one may be taken while the previous result waits.
//   If the receiver stalls, the finished result waits in a holding state
//   until the output register is free.
//   Reset clears the sequencer, the output valid and the limit register.
//   The matrix memory needs no clearing: each item writes every interior
//   cell before it reads it, and border cells are generated, not stored.
module barcode_damerau_levenshtein
    import bdl_pkg::*;
#(
    parameter int SEQ_LEN     = SEQ_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*IN_FIELD_W-1:0] s_tdata,     // src_packed, tgt_packed
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata,     // distance, over_limit, zero pad
    input  logic                    cfg_wr_en,
    input  logic [MAXD_W-1:0]       cfg_wr_data  // max_distance
);

    localparam int NSYM   = 1 << SYMBOL_BITS;
    localparam int CNT_W  = $clog2(SEQ_LEN);
    localparam int IDX_W  = $clog2(SEQ_LEN + 1);
    localparam int VAL_W  = $clog2(2 * SEQ_LEN + 1);
    localparam int TW     = $clog2(4 * SEQ_LEN + 1);
    localparam int DEPTH  = SEQ_LEN * SEQ_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PACK_W = (SEQ_LEN * SYMBOL_BITS > IN_FIELD_W) ?
                            SEQ_LEN * SYMBOL_BITS : IN_FIELD_W;
    localparam int CEIL_V = 2 * SEQ_LEN;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      ic_reg, ic_next;
    logic [CNT_W-1:0]      jc_reg, jc_next;
    logic [IDX_W-1:0]      col_match_reg;
    logic [IDX_W-1:0]      last_row_reg [NSYM];
    logic [MAXD_W-1:0]     max_distance_reg;
    logic [IN_FIELD_W-1:0] src_reg;
    logic [IN_FIELD_W-1:0] tgt_reg;
    logic [VAL_W-1:0]      dist_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [PACK_W-1:0]      src_ext;
    logic [PACK_W-1:0]      tgt_ext;
    logic [SYMBOL_BITS-1:0] src_sym [SEQ_LEN];
    logic [SYMBOL_BITS-1:0] tgt_sym [SEQ_LEN];

    logic                   accept;
    logic                   issue;
    logic                   row_end;
    logic                   last_cell;
    logic [SYMBOL_BITS-1:0] a_sym;
    logic [SYMBOL_BITS-1:0] b_sym;
    logic                   match;
    logic [IDX_W-1:0]       rm;
    logic [IDX_W-1:0]       cm;
    logic                   up_border;
    logic [VAL_W-1:0]       up_bval;
    logic [ADDR_W-1:0]      up_addr;
    logic                   tr_border;
    logic [VAL_W-1:0]       tr_bval;
    logic [ADDR_W-1:0]      tr_addr;

    // Compute stage, registered from the issue stage.
    logic                  p_valid_reg;
    logic [CNT_W-1:0]      p_ic_reg;
    logic [CNT_W-1:0]      p_jc_reg;
    logic [IDX_W-1:0]      p_rm_reg;
    logic [IDX_W-1:0]      p_cm_reg;
    logic                  p_match_reg;
    logic                  p_up_border_reg;
    logic [VAL_W-1:0]      p_up_bval_reg;
    logic                  p_tr_border_reg;
    logic [VAL_W-1:0]      p_tr_bval_reg;
    logic [VAL_W-1:0]      cell_prev_reg;
    logic [VAL_W-1:0]      up_prev_reg;

    logic [VAL_W-1:0]      rd_up;
    logic [VAL_W-1:0]      rd_tr;
    logic [VAL_W-1:0]      c_up;
    logic [VAL_W-1:0]      c_base;
    logic [VAL_W-1:0]      c_left;
    logic [VAL_W-1:0]      c_diag;
    logic [VAL_W-1:0]      cell_score;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  out_load;
    logic [DIST_W-1:0]     dist_sat;
    logic                  over_limit;

    assign src_ext = PACK_W'(src_reg);
    assign tgt_ext = PACK_W'(tgt_reg);

    for (genvar k = 0; k < SEQ_LEN; k++)
    begin : g_sym
        assign src_sym[k] = src_ext[k*SYMBOL_BITS +: SYMBOL_BITS];
        assign tgt_sym[k] = tgt_ext[k*SYMBOL_BITS +: SYMBOL_BITS];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_RUN);
    assign row_end   = (jc_reg == CNT_W'(SEQ_LEN - 1));
    assign last_cell = row_end && (ic_reg == CNT_W'(SEQ_LEN - 1));

    // Issue stage: look up the symbols, the gap table, and the two reads.
    always_comb
    begin
        a_sym = src_sym[ic_reg];
        b_sym = tgt_sym[jc_reg];
        match = (a_sym == b_sym);
        rm    = last_row_reg[b_sym];
        cm    = (jc_reg == '0) ? '0 : col_match_reg;

        // Cell above is a border cell only for the first source row.
        up_border = (ic_reg == '0);
        up_bval   = VAL_W'(jc_reg) + VAL_W'(1);
        up_addr   = ADDR_W'(ic_reg - CNT_W'(1)) * ADDR_W'(SEQ_LEN) + ADDR_W'(jc_reg);

        tr_border = 1'b1;
        tr_bval   = VAL_W'(CEIL_V);
        if (rm == '0 || cm == '0)
        begin
            tr_bval = VAL_W'(CEIL_V);
        end
        else if (rm == IDX_W'(1))
        begin
            tr_bval = VAL_W'(cm) - VAL_W'(1);
        end
        else if (cm == IDX_W'(1))
        begin
            tr_bval = VAL_W'(rm) - VAL_W'(1);
        end
        else
        begin
            tr_border = 1'b0;
        end
        tr_addr = ADDR_W'(rm - IDX_W'(2)) * ADDR_W'(SEQ_LEN)
                + ADDR_W'(cm - IDX_W'(2));
    end

    always_comb
    begin
        state_next = state_reg;
        ic_next    = ic_reg;
        jc_next    = jc_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    ic_next    = '0;
                    jc_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (row_end)
                begin
                    jc_next = '0;
                    ic_next = ic_reg + CNT_W'(1);
                end
                else
                begin
                    jc_next = jc_reg + CNT_W'(1);
                end
                if (last_cell)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ic_reg           <= '0;
            jc_reg           <= '0;
            col_match_reg    <= '0;
            p_valid_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            max_distance_reg <= '0;
            for (int s = 0; s < NSYM; s++)
            begin
                last_row_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ic_reg      <= ic_next;
            jc_reg      <= jc_next;
            p_valid_reg <= issue;
            if (cfg_wr_en)
            begin
                max_distance_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                col_match_reg <= '0;
                for (int s = 0; s < NSYM; s++)
                begin
                    last_row_reg[s] <= '0;
                end
            end
            else if (issue)
            begin
                col_match_reg <= match ? IDX_W'(jc_reg) + IDX_W'(1) : cm;
                // The gap table learns this source row only after the row ends.
                if (row_end)
                begin
                    last_row_reg[a_sym] <= IDX_W'(ic_reg) + IDX_W'(1);
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg <= s_tdata[IN_FIELD_W-1:0];
            tgt_reg <= s_tdata[2*IN_FIELD_W-1:IN_FIELD_W];
        end
        p_ic_reg        <= ic_reg;
        p_jc_reg        <= jc_reg;
        p_rm_reg        <= rm;
        p_cm_reg        <= cm;
        p_match_reg     <= match;
        p_up_border_reg <= up_border;
        p_up_bval_reg   <= up_bval;
        p_tr_border_reg <= tr_border;
        p_tr_bval_reg   <= tr_bval;
        if (p_valid_reg)
        begin
            cell_prev_reg <= cell_score;
            up_prev_reg   <= c_up;
        end
        if (state_reg == ST_FLUSH)
        begin
            dist_reg <= cell_score;
        end
        if (out_load)
        begin
            m_tdata_reg <= OUT_W'({over_limit, dist_sat});
        end
    end

    // Compute stage: first column of a row takes its left and diagonal
    // neighbors from the border rather than from the previous cell.
    always_comb
    begin
        c_up    = p_up_border_reg ? p_up_bval_reg : rd_up;
        c_base  = p_tr_border_reg ? p_tr_bval_reg : rd_tr;
        c_left  = (p_jc_reg == '0) ? VAL_W'(p_ic_reg) + VAL_W'(1) : cell_prev_reg;
        c_diag  = (p_jc_reg == '0) ? VAL_W'(p_ic_reg) : up_prev_reg;
        wr_addr = ADDR_W'(p_ic_reg) * ADDR_W'(SEQ_LEN) + ADDR_W'(p_jc_reg);
    end

    bdl_score_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (VAL_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (p_valid_reg),
        .wr_addr   (wr_addr),
        .wr_data   (cell_score),
        .rd_addr_a (up_addr),
        .rd_data_a (rd_up),
        .rd_addr_b (tr_addr),
        .rd_data_b (rd_tr)
    );

    bdl_cell_unit #(
        .VAL_W (VAL_W),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .TW    (TW)
    ) u_cell (
        .diag       (c_diag),
        .left       (c_left),
        .up         (c_up),
        .trans_base (c_base),
        .ic         (p_ic_reg),
        .jc         (p_jc_reg),
        .row_match  (p_rm_reg),
        .col_match  (p_cm_reg),
        .match      (p_match_reg),
        .score      (cell_score)
    );

    assign dist_sat   = (32'(dist_reg) > 32'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                        : DIST_W'(dist_reg);
    assign over_limit = (max_distance_reg != '0)
                     && (32'(dist_reg) > 32'(max_distance_reg));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "barcode_damerau_levenshtein_macros.svh"

    `BDL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept,
        !s_tready && state_reg == ST_RUN, "block ready right after taking an item")
    `BDL_ASSERT_IMP(a_flush_last_cell, clk, rst_n, state_reg == ST_FLUSH,
        p_valid_reg && p_ic_reg == CNT_W'(SEQ_LEN - 1)
        && p_jc_reg == CNT_W'(SEQ_LEN - 1), "flush without the last cell in flight")
    `BDL_ASSERT_IMP(a_gap_bounds, clk, rst_n, p_valid_reg,
        p_rm_reg <= IDX_W'(p_ic_reg) && p_cm_reg <= IDX_W'(p_jc_reg),
        "transposition source outside the scored region")
    `BDL_ASSERT_IMP(a_over_needs_limit, clk, rst_n,
        m_tvalid_reg && m_tdata_reg[OVER_BIT],
        max_distance_reg != '0, "over_limit set with the limit disabled")

endmodule
